FILE: rtl/nearest_seed_point_picker_core_defines.svh
// Assertion macros for the nearest seed point picker.
// Needs clk and rst in the scope where a macro is used.
`ifndef NEAREST_SEED_POINT_PICKER_CORE_DEFINES_SVH
`define NEAREST_SEED_POINT_PICKER_CORE_DEFINES_SVH

// check that a condition holds at every edge out of reset
`define NSPP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that a consequent holds in the cycle of its antecedent
`define NSPP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/nspp_pkg.sv
// Shared types and constants of the nearest seed point picker.
// No dependencies; imported by the controller, the datapath and the top level.
package nspp_pkg;

  localparam int COORD_W     = 20;
  localparam int RADIUS_W    = 20;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W + 1;
  localparam int SUM_W       = SQ_W + 2;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int POINT_W     = 3 * COORD_W;

  localparam int COUNT_OUT_W = 7;
  localparam int INDEX_OUT_W = 6;
  localparam int S_TDATA_W   = 64;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 24;
  localparam int M_PAD_W     = M_TDATA_W - (COUNT_OUT_W + INDEX_OUT_W + 4);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic CFG_IDX_RADIUS = 1'b0;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd80;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_SELECT   = 2'd1,
    KIND_DESELECT = 2'd2,
    KIND_REMOVE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic seek_scan;
    logic seek_copy;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scan_needed;
    logic  copy_needed;
    logic  last_issue;
    logic  pipe_empty;
    logic  out_free;
  } ctl_status_t;

endpackage

FILE: rtl/nspp_controller.sv
// Sequencer of the nearest seed point picker: takes an item, walks the table, commits.
// Depends on nspp_pkg.
module nspp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  nspp_pkg::ctl_status_t status,
  output nspp_pkg::ctl_cmd_t    cmd
);
  import nspp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.kind == KIND_SELECT && status.scan_needed) begin
          cmd.seek_scan = 1'b1;
          state_next    = ST_WALK;
        end else if (status.kind == KIND_REMOVE && status.copy_needed) begin
          cmd.seek_copy = 1'b1;
          state_next    = ST_WALK;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/nspp_datapath.sv
// Datapath of the nearest seed point picker: point memory, distance pipeline,
// selection state, radius register and result register. Depends on nspp_pkg.
`include "nearest_seed_point_picker_core_defines.svh"
module nspp_datapath #(
  parameter int MAX_SEEDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nspp_pkg::ctl_cmd_t              cmd,
  output nspp_pkg::ctl_status_t           status,
  input  logic [nspp_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [nspp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nspp_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nspp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nspp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nspp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import nspp_pkg::*;

  localparam int IW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = $clog2(MAX_SEEDS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEEDS);
  localparam logic [CW-1:0] ONE_C     = CW'(1);
  localparam logic [IW-1:0] ONE_I     = IW'(1);

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [RADIUS_W-1:0] radius;
  logic [R2_W-1:0]     r2;

  kind_t                     kind;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;

  logic [CW-1:0] count;
  logic [IW-1:0] held;
  logic          held_valid;
  logic          mark;

  logic [POINT_W-1:0] mem [MAX_SEEDS];
  logic [POINT_W-1:0] rd_data;
  logic [IW-1:0]      ptr;

  logic          v1, v2, v3, v4;
  logic [IW-1:0] idx1, idx2, idx3, idx4;
  logic [DIFF_W-1:0] ax, ay, az;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  best;
  logic [IW-1:0]     best_i;
  logic              have;

  logic               full;
  logic               copy_wr;
  logic               add_wr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [POINT_W-1:0] wr_data;

  logic [CW-1:0] count_next;
  logic [IW-1:0] held_next;
  logic          held_valid_next;
  logic          mark_next;
  logic          hit_next;
  logic          drop_next;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_RADIUS) ? CFG_DATA_W'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1] == CFG_IDX_RADIUS) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_W'(radius) * R2_W'(radius);
  end

  // item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_ADD;
    end else if (cmd.load) begin
      kind <= kind_t'(s_tuser[1:0]);
      px   <= signed'(s_tdata[COORD_W-1:0]);
      py   <= signed'(s_tdata[2*COORD_W-1:COORD_W]);
      pz   <= signed'(s_tdata[3*COORD_W-1:2*COORD_W]);
    end
  end

  // point memory
  assign full    = (count == COUNT_MAX);
  assign copy_wr = v1 && (kind == KIND_REMOVE);
  assign add_wr  = cmd.commit && (kind == KIND_ADD) && !full;
  assign wr_en   = copy_wr || add_wr;
  assign wr_addr = copy_wr ? (idx1 - ONE_I) : count[IW-1:0];
  assign wr_data = copy_wr ? rd_data : {pz, py, px};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seek_scan) begin
      ptr <= '0;
    end else if (cmd.seek_copy) begin
      ptr <= held + ONE_I;
    end else if (cmd.issue) begin
      ptr <= ptr + ONE_I;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1 && (kind == KIND_SELECT);
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= ptr;
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    ax   <= abs_diff(signed'(rd_data[COORD_W-1:0]), px);
    ay   <= abs_diff(signed'(rd_data[2*COORD_W-1:COORD_W]), py);
    az   <= abs_diff(signed'(rd_data[3*COORD_W-1:2*COORD_W]), pz);
    sqx  <= SQ_W'(ax) * SQ_W'(ax);
    sqy  <= SQ_W'(ay) * SQ_W'(ay);
    sqz  <= SQ_W'(az) * SQ_W'(az);
    sum  <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  end

  // keep the first least distance
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      have <= 1'b0;
    end else if (v4 && (!have || sum < best)) begin
      have   <= 1'b1;
      best   <= sum;
      best_i <= idx4;
    end
  end

  // item effects
  always_comb begin
    count_next      = count;
    held_next       = held;
    held_valid_next = held_valid;
    mark_next       = mark;
    hit_next        = 1'b0;
    drop_next       = 1'b0;
    unique case (kind)
      KIND_ADD: begin
        if (!full) begin
          count_next = count + ONE_C;
        end else begin
          drop_next = 1'b1;
        end
      end
      KIND_SELECT: begin
        if (have && best < SUM_W'(r2)) begin
          held_next       = best_i;
          held_valid_next = 1'b1;
          mark_next       = 1'b1;
          hit_next        = 1'b1;
        end
      end
      KIND_DESELECT: begin
        held_next       = '0;
        held_valid_next = 1'b0;
        mark_next       = 1'b0;
      end
      KIND_REMOVE: begin
        if (held_valid) begin
          if (CW'(held) < count) begin
            count_next = count - ONE_C;
          end
          held_next       = '0;
          held_valid_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      held       <= '0;
      held_valid <= 1'b0;
      mark       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count      <= count_next;
        held       <= held_next;
        held_valid <= held_valid_next;
        mark       <= mark_next;
      end
      m_tvalid <= cmd.commit || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {M_PAD_W'(0), drop_next, hit_next, mark_next, held_valid_next,
                  INDEX_OUT_W'(held_next), COUNT_OUT_W'(count_next)};
    end
  end

  // status to the sequencer
  assign status.kind        = kind;
  assign status.scan_needed = (count != '0);
  assign status.copy_needed = held_valid && ((CW'(held) + ONE_C) < count);
  assign status.last_issue  = (CW'(ptr) == (count - ONE_C));
  assign status.pipe_empty  = !(v1 || v2 || v3 || v4);
  assign status.out_free    = !m_tvalid || m_tready;

  `NSPP_ASSERT_ALWAYS(a_count_bound, count <= COUNT_MAX, "point count beyond table depth")
  `NSPP_ASSERT_IMPLY(a_held_in_table, held_valid, CW'(held) < count, "held index outside table")
  `NSPP_ASSERT_IMPLY(a_copy_in_table, copy_wr, (idx1 != '0) && (CW'(idx1) < count), "copy out of range")
  `NSPP_ASSERT_IMPLY(a_commit_drained, cmd.commit, !(v1 || v2 || v3 || v4), "commit before pipeline drained")

endmodule

FILE: rtl/nearest_seed_point_picker_core.sv
// Nearest seed point picker: a table of up to MAX_SEEDS 3D points that answers add,
// select nearest within radius, deselect and remove. One result item per input item.
// Select walks all N stored points; remove of held index k below N - 1 copies entries
// k + 1 to N - 1 down by one; add, deselect, a select on an empty table and a remove
// that moves nothing walk no entries. The point memory's single read port is walked
// one entry per cycle into a four-stage distance pipeline. No item is taken while one
// is in work, but a result may wait in the output register while the next item is
// accepted. Store entries need no clearing after reset.
module nearest_seed_point_picker_core #(
  parameter int MAX_SEEDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x [19:0], pos_y [39:20], pos_z [59:40], zero [63:60]
  input  logic [nspp_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind [1:0]
  input  logic [nspp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // point_count [6:0], chosen_index [12:7], index_valid [13], selected_mark [14],
  // hit [15], add_dropped [16], zero [23:17]
  output logic [nspp_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nspp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nspp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nspp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import nspp_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  nspp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nspp_datapath #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

endmodule
